### rtl/core/mtphm_pkg.sv
// ----------------------------------------------------------------------------
// mtphm_pkg: shared definitions for the multi-track peak-hold level meter
// Widths, reset values, register indexes, operation codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mtphm_pkg;

    // number of tracks and derived index width
    localparam int TRACKS   = 6;
    localparam int TRK_W    = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    // field widths
    localparam int LVL_W    = 14;
    localparam int HOLD_W   = 8;
    localparam int COOL_W   = 9;
    localparam int MASK_W   = 6;
    localparam int MASK_IW  = 3;
    localparam int TID_W    = 3;
    localparam int CFG_IW   = 3;
    localparam int CFG_W    = 14;

    // reset values, 1/64 dB units where a level
    localparam logic signed [LVL_W-1:0] FLOOR_RESET = -14'sd6144;
    localparam logic signed [LVL_W-1:0] CLIP_RESET  = 14'sd0;
    localparam logic [HOLD_W-1:0]       HOLD_RESET  = 8'd30;
    localparam logic [COOL_W-1:0]       COOL_RESET  = 9'd300;
    localparam logic [MASK_W-1:0]       MASK_RESET  = 6'h3f;

    // 0.5 dB decay step
    localparam int DECAY_STEP = 32;

    // last track index
    localparam logic [TRK_W-1:0] LAST_IDX = TRK_W'(TRACKS - 1);

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_FLOOR = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_CLIP  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_HOLD  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_COOL  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_MASK  = 3'd4;

    // input operation codes
    localparam logic OP_LEVEL = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DECIDE,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

### rtl/core/multi_track_peak_hold_meter.sv
// ----------------------------------------------------------------------------
// multi_track_peak_hold_meter: per-track level meter with peak hold and clip
// Level samples update live per-track state; a display tick walks the tracks
// through one shared update unit, decides the clip warning, then sends one
// result per track.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_stall      i_operation, i_track, i_level
//  out       output     o_out_valid / i_out_stall    o_track_id .. o_last
//  cfg       input      i_cfg_we                     i_cfg_idx, i_cfg_data
//
//  a tick walks the tracks through the shared track-update unit (one track per
//  cycle, then the warning decision) and then loads the output register, one
//  result per cycle while the output register is not stalled.
//  o_in_stall is high from tick transfer until its last result is loaded.
//  i_out_stall holds the output register; the result sequence waits behind it.
//  synchronous active-low reset restores all state except the output payload.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_track_peak_hold_meter (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input channel
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic                                  i_operation,
    input  wire logic [mtphm_pkg::TID_W-1:0]           i_track,
    input  wire logic signed [mtphm_pkg::LVL_W-1:0]    i_level,
    // output channel
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [mtphm_pkg::TID_W-1:0]                o_track_id,
    output logic signed [mtphm_pkg::LVL_W-1:0]         o_shown_level,
    output logic signed [mtphm_pkg::LVL_W-1:0]         o_shown_hold,
    output logic                                       o_enabled,
    output logic                                       o_clip_seen,
    output logic                                       o_named_in_warning,
    output logic                                       o_warning,
    output logic                                       o_last,
    // configuration
    input  wire logic                                  i_cfg_we,
    input  wire logic [mtphm_pkg::CFG_IW-1:0]          i_cfg_idx,
    input  wire logic [mtphm_pkg::CFG_W-1:0]           i_cfg_data
);
    import mtphm_pkg::*;

    // configuration registers
    logic signed [LVL_W-1:0] r_floor;
    logic signed [LVL_W-1:0] r_clip;
    logic [HOLD_W-1:0]       r_hold_ticks;
    logic [COOL_W-1:0]       r_warn_cool;
    logic [MASK_W-1:0]       r_mask;

    // per-track state
    logic signed [LVL_W-1:0] r_live_level [TRACKS];
    logic signed [LVL_W-1:0] r_live_max   [TRACKS];
    logic signed [LVL_W-1:0] r_disp_level [TRACKS];
    logic signed [LVL_W-1:0] r_disp_hold  [TRACKS];
    logic [HOLD_W-1:0]       r_hold_cnt   [TRACKS];
    logic [TRACKS-1:0]       r_clip_latch;
    logic [TRACKS-1:0]       r_pending;
    logic [TRACKS-1:0]       r_clip_seen;
    logic [TRACKS-1:0]       r_named;
    logic [COOL_W-1:0]       r_cool_cnt;
    logic                    r_any;
    logic                    r_warn;

    // sequencer
    t_state                  r_state;
    t_state                  n_state;
    logic [TRK_W-1:0]        r_idx;

    // output register
    logic                    r_out_valid;
    logic [TID_W-1:0]        r_o_track_id;
    logic signed [LVL_W-1:0] r_o_level;
    logic signed [LVL_W-1:0] r_o_hold;
    logic                    r_o_enabled;
    logic                    r_o_clip;
    logic                    r_o_named;
    logic                    r_o_warn;
    logic                    r_o_last;

    // control strobes
    logic                    s_in_xfer;
    logic                    s_sample;
    logic                    s_tick;
    logic                    s_walk;
    logic                    s_decide;
    logic                    s_load;
    logic                    s_idx_last;

    // input sample decode
    logic [TRK_W-1:0]        s_in_idx;
    logic                    s_in_ok;

    // shared track-update unit
    logic                    s_en_cur;
    logic signed [LVL_W-1:0] s_pk;
    logic signed [LVL_W-1:0] s_hold;
    logic signed [LVL_W:0]   s_dec;
    logic signed [LVL_W:0]   s_floor_x;
    logic signed [LVL_W-1:0] s_decayed;
    logic signed [LVL_W-1:0] s_new_hold;
    logic [HOLD_W-1:0]       s_new_cnt;

    // warning decision
    logic                    s_warn_now;

    // input transfer decode
    assign s_in_xfer  = i_in_valid && !o_in_stall;
    assign s_sample   = s_in_xfer && (i_operation == OP_LEVEL);
    assign s_tick     = s_in_xfer && (i_operation == OP_TICK);
    assign s_in_idx   = TRK_W'(i_track);
    assign s_in_ok    = (int'(i_track) < TRACKS);
    assign s_idx_last = (r_idx == LAST_IDX);

    // track enable for the track under the cursor
    assign s_en_cur = (int'(r_idx) < MASK_W) && r_mask[MASK_IW'(r_idx)];

    // hold update: new peak, count down, or decay toward the floor
    assign s_pk      = r_live_max[r_idx];
    assign s_hold    = r_disp_hold[r_idx];
    assign s_dec     = (LVL_W+1)'(s_hold) - (LVL_W+1)'(DECAY_STEP);
    assign s_floor_x = (LVL_W+1)'(r_floor);
    assign s_decayed = (s_dec < s_floor_x) ? r_floor : s_dec[LVL_W-1:0];

    always_comb begin
        s_new_hold = s_hold;
        s_new_cnt  = r_hold_cnt[r_idx];
        priority if (s_pk > s_hold) begin
            s_new_hold = s_pk;
            s_new_cnt  = r_hold_ticks;
        end else if (r_hold_cnt[r_idx] != '0) begin
            s_new_cnt  = r_hold_cnt[r_idx] - 1'b1;
        end else begin
            s_new_hold = s_decayed;
        end
    end

    // warning when a clip occurred and the cooldown has run out
    assign s_warn_now = r_any && (r_cool_cnt == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_tick) n_state = S_WALK;
            end
            S_WALK: begin
                if (s_idx_last) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (s_load && s_idx_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        s_walk     = 1'b0;
        s_decide   = 1'b0;
        s_load     = 1'b0;
        unique case (r_state)
            S_IDLE:   o_in_stall = 1'b0;
            S_WALK:   s_walk     = 1'b1;
            S_DECIDE: s_decide   = 1'b1;
            S_EMIT:   s_load     = !r_out_valid || !i_out_stall;
            default:  o_in_stall = 1'b1;
        endcase
    end

    // sequencer, per-track state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_floor      <= FLOOR_RESET;
            r_clip       <= CLIP_RESET;
            r_hold_ticks <= HOLD_RESET;
            r_warn_cool  <= COOL_RESET;
            r_mask       <= MASK_RESET;
            for (int i = 0; i < TRACKS; i++) begin
                r_live_level[i] <= FLOOR_RESET;
                r_live_max[i]   <= FLOOR_RESET;
                r_disp_level[i] <= FLOOR_RESET;
                r_disp_hold[i]  <= FLOOR_RESET;
                r_hold_cnt[i]   <= '0;
            end
            r_clip_latch <= '0;
            r_pending    <= '0;
            r_clip_seen  <= '0;
            r_named      <= '0;
            r_cool_cnt   <= '0;
            r_any        <= 1'b0;
            r_warn       <= 1'b0;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FLOOR: r_floor      <= LVL_W'(i_cfg_data);
                    CFG_CLIP:  r_clip       <= LVL_W'(i_cfg_data);
                    CFG_HOLD:  r_hold_ticks <= HOLD_W'(i_cfg_data);
                    CFG_COOL:  r_warn_cool  <= COOL_W'(i_cfg_data);
                    CFG_MASK:  r_mask       <= MASK_W'(i_cfg_data);
                    default: ;
                endcase
            end

            // level sample: latest level, running max, clip latch
            if (s_sample && s_in_ok) begin
                r_live_level[s_in_idx] <= i_level;
                if (i_level >= r_clip) r_clip_latch[s_in_idx] <= 1'b1;
                if (i_level > r_live_max[s_in_idx]) r_live_max[s_in_idx] <= i_level;
            end

            // tick start: cooldown step, clear clip summary
            if (s_tick) begin
                if (r_cool_cnt != '0) r_cool_cnt <= r_cool_cnt - 1'b1;
                r_any <= 1'b0;
                r_idx <= '0;
            end

            // walk one track per cycle
            if (s_walk) begin
                r_clip_seen[r_idx] <= s_en_cur && r_clip_latch[r_idx];
                if (s_en_cur) begin
                    r_disp_level[r_idx] <= r_live_level[r_idx];
                    r_clip_latch[r_idx] <= 1'b0;
                    r_live_max[r_idx]   <= r_floor;
                    r_disp_hold[r_idx]  <= s_new_hold;
                    r_hold_cnt[r_idx]   <= s_new_cnt;
                    if (r_clip_latch[r_idx]) begin
                        r_pending[r_idx] <= 1'b1;
                        r_any            <= 1'b1;
                    end
                end
                r_idx <= s_idx_last ? '0 : r_idx + 1'b1;
            end

            // warning decision over the pending clips
            if (s_decide) begin
                r_warn <= s_warn_now;
                if (s_warn_now) begin
                    r_named    <= r_pending;
                    r_pending  <= '0;
                    r_cool_cnt <= r_warn_cool;
                end else begin
                    r_named    <= '0;
                end
            end

            // result cursor
            if (s_load) begin
                r_idx <= s_idx_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_o_track_id <= TID_W'(r_idx);
            r_o_level    <= r_disp_level[r_idx];
            r_o_hold     <= r_disp_hold[r_idx];
            r_o_enabled  <= s_en_cur;
            r_o_clip     <= r_clip_seen[r_idx];
            r_o_named    <= r_named[r_idx];
            r_o_warn     <= r_warn;
            r_o_last     <= s_idx_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_track_id         = r_o_track_id;
    assign o_shown_level      = r_o_level;
    assign o_shown_hold       = r_o_hold;
    assign o_enabled          = r_o_enabled;
    assign o_clip_seen        = r_o_clip;
    assign o_named_in_warning = r_o_named;
    assign o_warning          = r_o_warn;
    assign o_last             = r_o_last;

endmodule

`default_nettype wire

### rtl/core/mtphm_checker.sv
// ----------------------------------------------------------------------------
// mtphm_checker: port-level checks for the peak-hold level meter
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mtphm_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  o_in_stall,
    input  wire logic                                  o_out_valid,
    input  wire logic                                  i_out_stall,
    input  wire logic [mtphm_pkg::TID_W-1:0]           o_track_id,
    input  wire logic signed [mtphm_pkg::LVL_W-1:0]    o_shown_level,
    input  wire logic signed [mtphm_pkg::LVL_W-1:0]    o_shown_hold,
    input  wire logic                                  o_enabled,
    input  wire logic                                  o_clip_seen,
    input  wire logic                                  o_named_in_warning,
    input  wire logic                                  o_warning,
    input  wire logic                                  o_last
);
    import mtphm_pkg::*;

    // reset leaves both channels quiet and ready
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("channels not quiet after reset");

    // the last result of a tick belongs to the highest track
    a_last_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_track_id == TID_W'(TRACKS - 1))
        else $error("last flag on wrong track");

    // a track named in a warning implies a warning this tick
    a_named_warn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_named_in_warning |-> o_warning)
        else $error("track named without warning");

    // a skipped track reports no clip
    a_clip_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clip_seen |-> o_enabled)
        else $error("clip reported on disabled track");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_track_id)
            && $stable(o_shown_level) && $stable(o_shown_hold)
            && $stable(o_enabled) && $stable(o_clip_seen)
            && $stable(o_named_in_warning) && $stable(o_warning) && $stable(o_last))
        else $error("stalled result changed");

endmodule

bind multi_track_peak_hold_meter mtphm_checker u_mtphm_checker (.*);

`default_nettype wire
